@@ hw/rtl/strongly_connected_components_defines.svh @@
// ----------------------------------------------------------------------------
// SCC assertion macros
// Shared concurrent assertion forms for the SCC block checkers.
// ----------------------------------------------------------------------------
`ifndef STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scc check failed");

// next-cycle implication
`define SCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc check failed");

`endif

@@ hw/rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// SCC package
// Types, constants and control codes shared by the SCC block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int NODE_W        = 6;
    localparam int CMD_W         = 2;
    localparam int CFG_W         = 7;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;
    localparam int CFG_RESET     = 64;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] component_index;
        logic              last_in_component;
        logic              last_of_run;
        logic              edges_dropped;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD0,
        ST_ADD1,
        ST_CLEAR,
        ST_RUN_INIT,
        ST_ROOT_CHK,
        ST_VISIT_A,
        ST_VISIT_B,
        ST_STEP,
        ST_EDGE,
        ST_CMP,
        ST_POP_A,
        ST_POP_B,
        ST_FRAME_POP,
        ST_RESTORE,
        ST_END
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_ADD0,
        OP_ADD1,
        OP_CLEAR,
        OP_RUN_INIT,
        OP_ROOT_CHK,
        OP_VISIT_A,
        OP_VISIT_B,
        OP_STEP,
        OP_EDGE,
        OP_CMP,
        OP_POP_A,
        OP_POP_B,
        OP_FRAME_POP,
        OP_RESTORE,
        OP_END
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic add_ok;
        logic root_end;
        logic root_visited;
        logic e_null;
        logic is_root;
        logic v_out;
        logic v_new;
        logic v_full;
        logic v_on;
        logic w_is_u;
        logic fp_last;
    } t_status;

endpackage

@@ hw/rtl/strongly_connected_components.sv @@
// ----------------------------------------------------------------------------
// Strongly connected components
// Edge table plus iterative Tarjan search, one result per node on a run.
// ----------------------------------------------------------------------------
// One transaction at a time: busy is high after acceptance until the work is
// done; an undefined command is taken without raising busy. An add drops the
// edge when a node is out of range or the table is full. A run checks each
// root index, visits each new node, walks its edges (comparing when the
// target is already on the stack) and pops each component, stepped by the
// controller through the edge, stack and frame memories.
// Results come one per strobe with gaps and cannot be held off; the last
// result of a run is on the ports in the first cycle in which busy is low.
module strongly_connected_components #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  scc_pkg::t_item             i_item,
    input  logic                       i_cfg_we,
    input  logic [scc_pkg::CFG_W-1:0]  i_cfg_wdata,
    output scc_pkg::t_result           o_result,
    output logic                       o_result_valid
);

    scc_pkg::t_ctrl   ctrl;
    scc_pkg::t_status status;

    scc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_item.cmd),
        .i_status (status),
        .o_ctrl   (ctrl),
        .busy     (busy)
    );

    scc_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

@@ hw/rtl/scc_ctrl.sv @@
// ----------------------------------------------------------------------------
// SCC controller
// Sequences edge loading, clearing and the iterative Tarjan search.
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [scc_pkg::CMD_W-1:0]  i_cmd,
    input  scc_pkg::t_status           i_status,
    output scc_pkg::t_ctrl             o_ctrl,
    output logic                       busy
);

    scc_pkg::t_state r_state;
    scc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scc_pkg::ST_IDLE: begin
                if (start) begin
                    priority if (i_cmd == scc_pkg::CMD_ADD)   n_state = scc_pkg::ST_ADD0;
                    else if (i_cmd == scc_pkg::CMD_RUN)       n_state = scc_pkg::ST_RUN_INIT;
                    else if (i_cmd == scc_pkg::CMD_CLEAR)     n_state = scc_pkg::ST_CLEAR;
                    else                                      n_state = scc_pkg::ST_IDLE;
                end
            end
            scc_pkg::ST_ADD0: begin
                n_state = i_status.add_ok ? scc_pkg::ST_ADD1 : scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_ADD1:     n_state = scc_pkg::ST_IDLE;
            scc_pkg::ST_CLEAR:    n_state = scc_pkg::ST_IDLE;
            scc_pkg::ST_RUN_INIT: n_state = scc_pkg::ST_ROOT_CHK;
            scc_pkg::ST_ROOT_CHK: begin
                priority if (i_status.root_end)     n_state = scc_pkg::ST_END;
                else if (i_status.root_visited)     n_state = scc_pkg::ST_ROOT_CHK;
                else                                n_state = scc_pkg::ST_VISIT_A;
            end
            scc_pkg::ST_VISIT_A: n_state = scc_pkg::ST_VISIT_B;
            scc_pkg::ST_VISIT_B: n_state = scc_pkg::ST_STEP;
            scc_pkg::ST_STEP: begin
                priority if (!i_status.e_null)  n_state = scc_pkg::ST_EDGE;
                else if (i_status.is_root)      n_state = scc_pkg::ST_POP_A;
                else                            n_state = scc_pkg::ST_FRAME_POP;
            end
            scc_pkg::ST_EDGE: begin
                priority if (i_status.v_out)    n_state = scc_pkg::ST_STEP;
                else if (i_status.v_new) begin
                    n_state = i_status.v_full ? scc_pkg::ST_STEP : scc_pkg::ST_VISIT_A;
                end
                else if (i_status.v_on)         n_state = scc_pkg::ST_CMP;
                else                            n_state = scc_pkg::ST_STEP;
            end
            scc_pkg::ST_CMP:   n_state = scc_pkg::ST_STEP;
            scc_pkg::ST_POP_A: n_state = scc_pkg::ST_POP_B;
            scc_pkg::ST_POP_B: begin
                n_state = i_status.w_is_u ? scc_pkg::ST_FRAME_POP : scc_pkg::ST_POP_A;
            end
            scc_pkg::ST_FRAME_POP: begin
                n_state = i_status.fp_last ? scc_pkg::ST_ROOT_CHK : scc_pkg::ST_RESTORE;
            end
            scc_pkg::ST_RESTORE: n_state = scc_pkg::ST_STEP;
            scc_pkg::ST_END:     n_state = scc_pkg::ST_IDLE;
            default:             n_state = scc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.accept = 1'b0;
        busy          = 1'b1;
        unique case (r_state)
            scc_pkg::ST_IDLE: begin
                o_ctrl.op     = scc_pkg::OP_IDLE;
                o_ctrl.accept = start;
                busy          = 1'b0;
            end
            scc_pkg::ST_ADD0:      o_ctrl.op = scc_pkg::OP_ADD0;
            scc_pkg::ST_ADD1:      o_ctrl.op = scc_pkg::OP_ADD1;
            scc_pkg::ST_CLEAR:     o_ctrl.op = scc_pkg::OP_CLEAR;
            scc_pkg::ST_RUN_INIT:  o_ctrl.op = scc_pkg::OP_RUN_INIT;
            scc_pkg::ST_ROOT_CHK:  o_ctrl.op = scc_pkg::OP_ROOT_CHK;
            scc_pkg::ST_VISIT_A:   o_ctrl.op = scc_pkg::OP_VISIT_A;
            scc_pkg::ST_VISIT_B:   o_ctrl.op = scc_pkg::OP_VISIT_B;
            scc_pkg::ST_STEP:      o_ctrl.op = scc_pkg::OP_STEP;
            scc_pkg::ST_EDGE:      o_ctrl.op = scc_pkg::OP_EDGE;
            scc_pkg::ST_CMP:       o_ctrl.op = scc_pkg::OP_CMP;
            scc_pkg::ST_POP_A:     o_ctrl.op = scc_pkg::OP_POP_A;
            scc_pkg::ST_POP_B:     o_ctrl.op = scc_pkg::OP_POP_B;
            scc_pkg::ST_FRAME_POP: o_ctrl.op = scc_pkg::OP_FRAME_POP;
            scc_pkg::ST_RESTORE:   o_ctrl.op = scc_pkg::OP_RESTORE;
            scc_pkg::ST_END:       o_ctrl.op = scc_pkg::OP_END;
            default:               o_ctrl.op = scc_pkg::OP_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/scc_datapath.sv @@
// ----------------------------------------------------------------------------
// SCC datapath
// Edge table, node stack, frame stack and search registers.
// ----------------------------------------------------------------------------
module scc_datapath #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scc_pkg::t_ctrl             i_ctrl,
    input  scc_pkg::t_item             i_item,
    input  logic                       i_cfg_we,
    input  logic [scc_pkg::CFG_W-1:0]  i_cfg_wdata,
    output scc_pkg::t_status           o_status,
    output scc_pkg::t_result           o_result,
    output logic                       o_result_valid
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PW = $clog2(MAX_EDGES + 1);
    localparam int FW = NW + PW + NW + NW;
    localparam logic [PW-1:0] NULL_PTR = PW'(MAX_EDGES);

    typedef struct packed {
        logic [NW-1:0] node;
        logic [PW-1:0] edge_ptr;
        logic [NW-1:0] low;
        logic [NW-1:0] visit;
    } t_frame;

    // config and edge bookkeeping
    logic [scc_pkg::CFG_W-1:0]  r_node_count;
    logic [scc_pkg::CFG_W-1:0]  n7;
    logic [NW-1:0]              r_src;
    logic [NW-1:0]              r_dst;
    logic [scc_pkg::NODE_W-1:0] r_src_raw;
    logic [scc_pkg::NODE_W-1:0] r_dst_raw;
    logic [PW-1:0]              r_total;
    logic                       r_dropped;
    logic [MAX_NODES-1:0]       r_list_valid;

    // search state
    logic [MAX_NODES-1:0] r_visited;
    logic [MAX_NODES-1:0] r_onstk;
    logic [NW:0]          r_timer;
    logic [NW:0]          r_sp;
    logic [NW:0]          r_fp;
    logic [NW:0]          r_root;
    logic [NW-1:0]        r_comp;
    logic [NW-1:0]        r_v;
    logic [NW-1:0]        r_u;
    logic [PW-1:0]        r_e;
    logic [NW-1:0]        r_lu;
    logic [NW-1:0]        r_vu;

    // memories and read registers
    logic [NW-1:0] m_tgt  [MAX_EDGES];
    logic [PW-1:0] m_lnk  [MAX_EDGES];
    logic [EW-1:0] m_head [MAX_NODES];
    logic [EW-1:0] m_tail [MAX_NODES];
    logic [NW-1:0] m_vis  [MAX_NODES];
    logic [NW-1:0] m_nstk [MAX_NODES];
    logic [FW-1:0] m_frm  [MAX_NODES];
    logic [NW-1:0] r_tgt_rd;
    logic [PW-1:0] r_lnk_rd;
    logic [EW-1:0] r_head_rd;
    logic [EW-1:0] r_tail_rd;
    logic [NW-1:0] r_vis_rd;
    logic [NW-1:0] r_nstk_rd;
    t_frame        r_frm_rd;

    // output staging
    scc_pkg::t_result r_pend;
    logic             r_pend_v;
    scc_pkg::t_result r_out;
    logic             r_out_v;

    logic          lnk_we;
    logic [EW-1:0] lnk_wa;
    logic [PW-1:0] lnk_wd;
    logic [NW:0]   sp_m1;
    logic [NW:0]   fp_m1;
    logic [NW:0]   fp_m2;
    logic [NW-1:0] w;
    t_frame        top_frame;

    always_comb begin
        if (r_node_count == '0) begin
            n7 = scc_pkg::CFG_W'(1);
        end else if (r_node_count > scc_pkg::CFG_W'(MAX_NODES)) begin
            n7 = scc_pkg::CFG_W'(MAX_NODES);
        end else begin
            n7 = r_node_count;
        end
    end

    assign sp_m1 = r_sp - (NW+1)'(1);
    assign fp_m1 = r_fp - (NW+1)'(1);
    assign fp_m2 = r_fp - (NW+1)'(2);
    assign w     = r_nstk_rd;

    assign top_frame.node     = r_u;
    assign top_frame.edge_ptr = r_e;
    assign top_frame.low      = r_lu;
    assign top_frame.visit    = r_vu;

    always_comb begin
        o_status.add_ok = (scc_pkg::CFG_W'(r_src_raw) < n7)
                       && (scc_pkg::CFG_W'(r_dst_raw) < n7)
                       && (r_total < PW'(MAX_EDGES));
        o_status.root_end     = scc_pkg::CFG_W'(r_root) >= n7;
        o_status.root_visited = r_visited[r_root[NW-1:0]];
        o_status.e_null       = r_e == NULL_PTR;
        o_status.is_root      = r_lu == r_vu;
        o_status.v_out        = scc_pkg::CFG_W'(r_tgt_rd) >= n7;
        o_status.v_new        = !r_visited[r_tgt_rd];
        o_status.v_full       = (r_sp >= (NW+1)'(MAX_NODES)) || (r_fp >= (NW+1)'(MAX_NODES));
        o_status.v_on         = r_onstk[r_tgt_rd];
        o_status.w_is_u       = w == r_u;
        o_status.fp_last      = r_fp == (NW+1)'(1);
    end

    always_comb begin
        lnk_we = 1'b0;
        lnk_wa = r_total[EW-1:0];
        lnk_wd = NULL_PTR;
        if (i_ctrl.op == scc_pkg::OP_ADD0 && o_status.add_ok) begin
            lnk_we = 1'b1;
        end else if (i_ctrl.op == scc_pkg::OP_ADD1 && r_list_valid[r_src]) begin
            lnk_we = 1'b1;
            lnk_wa = r_tail_rd;
            lnk_wd = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == scc_pkg::OP_ADD0 && o_status.add_ok) begin
            m_tgt[r_total[EW-1:0]] <= r_dst;
        end
        if (lnk_we) begin
            m_lnk[lnk_wa] <= lnk_wd;
        end
        r_tgt_rd <= m_tgt[r_e[EW-1:0]];
        r_lnk_rd <= m_lnk[r_e[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == scc_pkg::OP_ADD1) begin
            if (!r_list_valid[r_src]) begin
                m_head[r_src] <= r_total[EW-1:0];
            end
            m_tail[r_src] <= r_total[EW-1:0];
        end
        r_head_rd <= m_head[r_v];
        r_tail_rd <= m_tail[r_src];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == scc_pkg::OP_VISIT_B) begin
            m_vis[r_v]            <= r_timer[NW-1:0];
            m_nstk[r_sp[NW-1:0]]  <= r_v;
            if (r_fp != '0) begin
                m_frm[fp_m1[NW-1:0]] <= top_frame;
            end
        end
        r_vis_rd  <= m_vis[r_tgt_rd];
        r_nstk_rd <= m_nstk[sp_m1[NW-1:0]];
        r_frm_rd  <= m_frm[fp_m2[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_src_raw <= i_item.src_node;
            r_dst_raw <= i_item.dst_node;
            r_src     <= i_item.src_node[NW-1:0];
            r_dst     <= i_item.dst_node[NW-1:0];
        end
        unique case (i_ctrl.op)
            scc_pkg::OP_ROOT_CHK: r_v <= r_root[NW-1:0];
            scc_pkg::OP_EDGE: begin
                r_v <= r_tgt_rd;
                r_e <= r_lnk_rd;
            end
            scc_pkg::OP_VISIT_B: begin
                r_u  <= r_v;
                r_e  <= r_list_valid[r_v] ? PW'(r_head_rd) : NULL_PTR;
                r_lu <= r_timer[NW-1:0];
                r_vu <= r_timer[NW-1:0];
            end
            scc_pkg::OP_CMP: begin
                if (r_vis_rd < r_lu) r_lu <= r_vis_rd;
            end
            scc_pkg::OP_RESTORE: begin
                r_u  <= r_frm_rd.node;
                r_e  <= r_frm_rd.edge_ptr;
                r_vu <= r_frm_rd.visit;
                r_lu <= (r_lu < r_frm_rd.low) ? r_lu : r_frm_rd.low;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= scc_pkg::CFG_W'(scc_pkg::CFG_RESET);
            r_total      <= '0;
            r_dropped    <= 1'b0;
            r_list_valid <= '0;
            r_visited    <= '0;
            r_onstk      <= '0;
            r_timer      <= '0;
            r_sp         <= '0;
            r_fp         <= '0;
            r_root       <= '0;
            r_comp       <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            r_out_v <= 1'b0;
            unique case (i_ctrl.op)
                scc_pkg::OP_ADD0: begin
                    if (!o_status.add_ok) r_dropped <= 1'b1;
                end
                scc_pkg::OP_ADD1: begin
                    r_list_valid[r_src] <= 1'b1;
                    r_total             <= r_total + PW'(1);
                end
                scc_pkg::OP_CLEAR: begin
                    r_list_valid <= '0;
                    r_total      <= '0;
                    r_dropped    <= 1'b0;
                end
                scc_pkg::OP_RUN_INIT: begin
                    r_visited <= '0;
                    r_onstk   <= '0;
                    r_timer   <= '0;
                    r_sp      <= '0;
                    r_fp      <= '0;
                    r_root    <= '0;
                    r_comp    <= '0;
                    r_pend_v  <= 1'b0;
                end
                scc_pkg::OP_ROOT_CHK: begin
                    if (!o_status.root_end && o_status.root_visited) begin
                        r_root <= r_root + (NW+1)'(1);
                    end
                end
                scc_pkg::OP_VISIT_B: begin
                    r_visited[r_v] <= 1'b1;
                    r_onstk[r_v]   <= 1'b1;
                    r_timer        <= r_timer + (NW+1)'(1);
                    r_sp           <= r_sp + (NW+1)'(1);
                    r_fp           <= r_fp + (NW+1)'(1);
                end
                scc_pkg::OP_POP_A: r_sp <= sp_m1;
                scc_pkg::OP_POP_B: begin
                    r_onstk[w] <= 1'b0;
                    if (r_pend_v) begin
                        r_out   <= r_pend;
                        r_out_v <= 1'b1;
                    end
                    r_pend.node              <= scc_pkg::NODE_W'(w);
                    r_pend.component_index   <= scc_pkg::NODE_W'(r_comp);
                    r_pend.last_in_component <= o_status.w_is_u;
                    r_pend.last_of_run       <= 1'b0;
                    r_pend.edges_dropped     <= r_dropped;
                    r_pend_v                 <= 1'b1;
                    if (o_status.w_is_u) r_comp <= r_comp + NW'(1);
                end
                scc_pkg::OP_FRAME_POP: begin
                    r_fp <= fp_m1;
                    if (o_status.fp_last) r_root <= r_root + (NW+1)'(1);
                end
                scc_pkg::OP_END: begin
                    if (r_pend_v) begin
                        r_out.node              <= r_pend.node;
                        r_out.component_index   <= r_pend.component_index;
                        r_out.last_in_component <= r_pend.last_in_component;
                        r_out.last_of_run       <= 1'b1;
                        r_out.edges_dropped     <= r_pend.edges_dropped;
                        r_out_v                 <= 1'b1;
                    end
                    r_pend_v <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_v;

endmodule

@@ hw/rtl/scc_checker.sv @@
// ----------------------------------------------------------------------------
// SCC port checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "strongly_connected_components_defines.svh"

module scc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input scc_pkg::t_item             i_item,
    input scc_pkg::t_result           o_result,
    input logic                       o_result_valid
);

    logic accept;
    assign accept = start && !busy;

    `SCC_ASSERT_NXT(a_busy_after_work, i_clk, i_rst_n, accept && (i_item.cmd != scc_pkg::CMD_NOP), busy)
    `SCC_ASSERT_NXT(a_no_result_after_accept, i_clk, i_rst_n, accept, !o_result_valid)
    `SCC_ASSERT_NXT(a_quiet_after_last, i_clk, i_rst_n, o_result_valid && o_result.last_of_run, !o_result_valid)
    `SCC_ASSERT_IMP(a_last_closes_comp, i_clk, i_rst_n, o_result_valid && o_result.last_of_run, o_result.last_in_component)

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result       (o_result),
    .o_result_valid (o_result_valid)
);

@@ tb/sv/scc_checker.sv @@
// ----------------------------------------------------------------------------
// SCC result checker
// Watches the command, configuration and result channels of the SCC block,
// keeps its own edge table, runs the component search on every run command
// and compares each result with the oldest expected one.
// ----------------------------------------------------------------------------
module scc_tb_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  scc_pkg::t_item       i_item,
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_wdata,
    input  scc_pkg::t_result     i_result,
    input  logic                 i_result_valid,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int NODES   = 64;
    localparam int EDGES   = 256;
    localparam int NO_EDGE = EDGES;

    int               node_limit;
    int               edge_dst [EDGES];
    int               edge_next[EDGES];
    int               first_edge[NODES];
    int               last_edge[NODES];
    int               edges_held;
    bit               any_dropped;
    scc_pkg::t_result expected_results[$];

    assign o_outstanding = expected_results.size();

    function automatic int active_nodes();
        if (node_limit == 0) return 1;
        if (node_limit > NODES) return NODES;
        return node_limit;
    endfunction

    task automatic empty_table();
        for (int i = 0; i < NODES; i++) begin
            first_edge[i] = NO_EDGE;
            last_edge[i]  = NO_EDGE;
        end
        edges_held  = 0;
        any_dropped = 0;
    endtask

    task automatic store_edge(input int src, input int dst);
        int n;
        n = active_nodes();
        if (src >= n || dst >= n || edges_held >= EDGES) begin
            any_dropped = 1;
        end else begin
            edge_dst[edges_held]  = dst;
            edge_next[edges_held] = NO_EDGE;
            if (first_edge[src] == NO_EDGE) first_edge[src] = edges_held;
            else edge_next[last_edge[src]] = edges_held;
            last_edge[src] = edges_held;
            edges_held++;
        end
    endtask

    task automatic predict_components();
        int               order[NODES];
        int               low[NODES];
        bit               stacked[NODES];
        int               node_stk[NODES];
        int               frm_node[NODES];
        int               frm_edge[NODES];
        int               n, sp, fp, comp, timer, u, e, v, w, p;
        scc_pkg::t_result found[$];
        scc_pkg::t_result r;
        n = active_nodes();
        sp = 0; fp = 0; comp = 0; timer = 0;
        for (int i = 0; i < NODES; i++) begin
            order[i] = NODES;
            stacked[i] = 0;
        end
        for (int root = 0; root < n; root++) begin
            if (order[root] != NODES) continue;
            order[root] = timer; low[root] = timer; timer++;
            node_stk[sp++] = root; stacked[root] = 1;
            frm_node[fp] = root; frm_edge[fp] = first_edge[root]; fp++;
            while (fp > 0) begin
                u = frm_node[fp-1];
                e = frm_edge[fp-1];
                if (e < EDGES) begin
                    v = edge_dst[e];
                    frm_edge[fp-1] = edge_next[e];
                    if (v >= n) continue;
                    if (order[v] == NODES) begin
                        order[v] = timer; low[v] = timer; timer++;
                        node_stk[sp++] = v; stacked[v] = 1;
                        frm_node[fp] = v; frm_edge[fp] = first_edge[v]; fp++;
                    end else if (stacked[v] && order[v] < low[u]) begin
                        low[u] = order[v];
                    end
                    continue;
                end
                if (low[u] == order[u]) begin
                    while (sp > 0) begin
                        w = node_stk[--sp];
                        stacked[w] = 0;
                        r.node              = w[5:0];
                        r.component_index   = comp[5:0];
                        r.last_in_component = (w == u);
                        r.last_of_run       = 1'b0;
                        r.edges_dropped     = any_dropped;
                        found = {found, r};
                        if (w == u) break;
                    end
                    comp++;
                end
                fp--;
                if (fp > 0) begin
                    p = frm_node[fp-1];
                    if (low[u] < low[p]) low[p] = low[u];
                end
            end
        end
        if (found.size() > 0) found[found.size()-1].last_of_run = 1'b1;
        expected_results = {expected_results, found};
    endtask

    always @(posedge i_clk) begin
        scc_pkg::t_result want;
        if (!i_rst_n) begin
            node_limit = scc_pkg::CFG_RESET;
            empty_table();
            expected_results.delete();
            o_mismatches <= 0;
        end else begin
            if (i_cfg_we) node_limit = i_cfg_wdata;
            if (start && !busy) begin
                case (i_item.cmd)
                    scc_pkg::CMD_ADD:   store_edge(i_item.src_node, i_item.dst_node);
                    scc_pkg::CMD_RUN:   predict_components();
                    scc_pkg::CMD_CLEAR: empty_table();
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, i_result);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.node != i_result.node
                        || want.component_index != i_result.component_index
                        || want.last_in_component != i_result.last_in_component
                        || want.last_of_run != i_result.last_of_run
                        || want.edges_dropped != i_result.edges_dropped) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, want, i_result);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// SCC testbench top
// Drives edge, run, clear and stray commands with random gaps and node count
// settings, fills the edge table once, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG = 20000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    scc_pkg::t_item   i_item;
    logic             i_cfg_we;
    logic [6:0]       i_cfg_wdata;
    scc_pkg::t_result o_result;
    logic             o_result_valid;
    int               mismatches;
    int               outstanding;
    int               quiet_cycles;
    int               node_setting;
    bit               burst;
    int               sent;

    strongly_connected_components uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    scc_tb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_result       (o_result),
        .i_result_valid (o_result_valid),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int live_nodes();
        if (node_setting == 0) return 1;
        if (node_setting > 64) return 64;
        return node_setting;
    endfunction

    task automatic send(input logic [1:0] cmd, input int src, input int dst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_item.cmd      <= cmd;
        i_item.src_node <= src[5:0];
        i_item.dst_node <= dst[5:0];
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || outstanding != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_nodes(input int value);
        drain();
        node_setting = value;
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[6:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_edge();
        int n;
        n = live_nodes();
        if ($urandom_range(0, 9) == 0)
            send(scc_pkg::CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
        else
            send(scc_pkg::CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
    endtask

    initial begin
        int pick, edges_in_phase;
        start        = 0;
        i_item       = '0;
        i_cfg_we     = 0;
        i_cfg_wdata  = '0;
        i_rst_n      = 0;
        quiet_cycles = 0;
        node_setting = scc_pkg::CFG_RESET;
        burst        = 0;
        sent         = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero node count, bad edges, stray command
        set_nodes(0);
        send(scc_pkg::CMD_ADD, 0, 0);
        send(scc_pkg::CMD_ADD, 0, 1);
        send(scc_pkg::CMD_RUN, 0, 0);
        send(scc_pkg::CMD_NOP, 63, 63);
        send(scc_pkg::CMD_CLEAR, 0, 0);
        send(scc_pkg::CMD_RUN, 0, 0);
        // above max count, cycle plus tail, self loop on top node
        set_nodes(127);
        send(scc_pkg::CMD_ADD, 0, 1);
        send(scc_pkg::CMD_ADD, 1, 2);
        send(scc_pkg::CMD_ADD, 2, 0);
        send(scc_pkg::CMD_ADD, 2, 3);
        send(scc_pkg::CMD_ADD, 63, 63);
        send(scc_pkg::CMD_ADD, 63, 0);
        send(scc_pkg::CMD_ADD, 4, 40);
        send(scc_pkg::CMD_ADD, 3, 4);
        send(scc_pkg::CMD_RUN, 0, 0);
        send(scc_pkg::CMD_RUN, 0, 0);
        // stale edges after lowering the count
        set_nodes(5);
        send(scc_pkg::CMD_RUN, 0, 0);
        set_nodes(1);
        send(scc_pkg::CMD_RUN, 0, 0);

        // full edge table
        set_nodes(64);
        burst = 1;
        send(scc_pkg::CMD_CLEAR, 0, 0);
        repeat (260) send(scc_pkg::CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
        burst = 0;
        send(scc_pkg::CMD_RUN, 0, 0);

        while (sent < 370) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) set_nodes(($urandom_range(0, 1) == 0) ? 0 : 127);
            else if (pick < 3) set_nodes($urandom_range(65, 127));
            else set_nodes($urandom_range(1, 64));
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) send(scc_pkg::CMD_CLEAR, 0, 0);
            edges_in_phase = $urandom_range(0, (live_nodes() < 10) ? 10 : 40);
            repeat (edges_in_phase) begin
                if ($urandom_range(0, 19) == 0)
                    send(scc_pkg::CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63));
                else
                    random_edge();
            end
            send(scc_pkg::CMD_RUN, 0, 0);
            if ($urandom_range(0, 3) == 0) send(scc_pkg::CMD_RUN, 0, 0);
            if ($urandom_range(0, 4) == 0 && live_nodes() > 1) begin
                set_nodes($urandom_range(1, live_nodes() - 1));
                send(scc_pkg::CMD_RUN, 0, 0);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
